### design/ptzpb_pkg.sv
// Shared types and constants for the PTZ command packet builder.
package ptzpb_pkg;

  localparam int unsigned PktMax = 15;
  localparam int unsigned LenW   = 4;

  localparam logic [7:0] PktHeader = 8'h81;
  localparam logic [7:0] PktTerm   = 8'hFF;

  localparam logic [4:0] PanSpeedMax  = 5'd24;
  localparam logic [4:0] TiltSpeedMax = 5'd20;

  // Register indexes on the configuration port
  localparam logic [1:0] RegPanSpeed  = 2'd0;
  localparam logic [1:0] RegTiltSpeed = 2'd1;

  typedef enum logic [3:0] {
    MODE_ABS_MOVE = 4'd0,
    MODE_REL_MOVE = 4'd1,
    MODE_ZOOM_SET = 4'd2,
    MODE_HOME     = 4'd3,
    MODE_PRESET   = 4'd4,
    MODE_FOCUS    = 4'd5,
    MODE_DRIVE    = 4'd6,
    MODE_ZOOM_RUN = 4'd7,
    MODE_POS_INQ  = 4'd8,
    MODE_ZOOM_INQ = 4'd9
  } mode_e;

  // Command as held in the input register
  typedef struct packed {
    logic [3:0]         mode;
    logic [2:0]         action;
    logic signed [15:0] pan_target;
    logic signed [15:0] tilt_target;
    logic signed [15:0] zoom_target;
    logic [7:0]         preset_number;
  } cmd_t;

  // Assembled packet: bytes in send order and byte count
  typedef struct packed {
    logic [PktMax-1:0][7:0] bytes;
    logic [LenW-1:0]        len;
  } pkt_t;

endpackage

### design/ptzpb_builder.sv
// Combinational assembly of one command packet from a held command.
module ptzpb_builder (
  input  ptzpb_pkg::cmd_t cmd_i,
  input  logic [4:0]      pan_speed_i,
  input  logic [4:0]      tilt_speed_i,
  output ptzpb_pkg::pkt_t pkt_o
);
  import ptzpb_pkg::*;

  localparam logic signed [15:0] PanHigh  = 16'sh0990;
  localparam logic signed [15:0] PanLow   = -16'sh0990;
  localparam logic signed [15:0] TiltHigh = 16'sh0510;
  localparam logic signed [15:0] TiltLow  = -16'sh01B0;
  localparam logic signed [15:0] ZoomHigh = 16'sh4000;
  localparam logic signed [15:0] ZoomLow  = 16'sh0000;

  localparam logic [2:0] ActPresetSet   = 3'd1;
  localparam logic [2:0] ActPresetClear = 3'd2;
  localparam logic [2:0] ActFocusManual = 3'd0;
  localparam logic [2:0] ActFocusNear   = 3'd2;
  localparam logic [2:0] ActFocusFar    = 3'd3;
  localparam logic [2:0] ActFocusStop   = 3'd4;
  localparam logic [2:0] ActDriveUp     = 3'd1;
  localparam logic [2:0] ActDriveDown   = 3'd2;
  localparam logic [2:0] ActDriveLeft   = 3'd3;
  localparam logic [2:0] ActDriveRight  = 3'd4;
  localparam logic [2:0] ActZoomIn      = 3'd0;
  localparam logic [2:0] ActZoomStop    = 3'd2;

  function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                 input logic signed [15:0] lo,
                                                 input logic signed [15:0] hi);
    logic signed [15:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  logic signed [15:0] pan_c, tilt_c, zoom_c;
  logic [7:0]         ps_byte, ts_byte;
  logic [7:0]         sub_a, sub_b;

  assign pan_c   = clamp16(cmd_i.pan_target, PanLow, PanHigh);
  assign tilt_c  = clamp16(cmd_i.tilt_target, TiltLow, TiltHigh);
  assign zoom_c  = clamp16(cmd_i.zoom_target, ZoomLow, ZoomHigh);
  assign ps_byte = {3'b000, pan_speed_i};
  assign ts_byte = {3'b000, tilt_speed_i};

  // Decode the action-dependent bytes for the current mode
  always_comb begin
    sub_a = 8'h00;
    sub_b = 8'h00;
    unique case (mode_e'(cmd_i.mode))
      MODE_PRESET: begin
        case (cmd_i.action)
          ActPresetSet:   sub_a = 8'h01;
          ActPresetClear: sub_a = 8'h00;
          default:        sub_a = 8'h02;
        endcase
      end
      MODE_FOCUS: begin
        case (cmd_i.action)
          ActFocusManual: begin sub_a = 8'h38; sub_b = 8'h03; end
          ActFocusNear:   begin sub_a = 8'h08; sub_b = 8'h02; end
          ActFocusFar:    begin sub_a = 8'h08; sub_b = 8'h03; end
          ActFocusStop:   begin sub_a = 8'h08; sub_b = 8'h00; end
          default:        begin sub_a = 8'h38; sub_b = 8'h02; end
        endcase
      end
      MODE_DRIVE: begin
        // sub_a is horizontal direction, sub_b vertical
        sub_a = 8'h03;
        sub_b = 8'h03;
        case (cmd_i.action)
          ActDriveUp:    sub_b = 8'h01;
          ActDriveDown:  sub_b = 8'h02;
          ActDriveLeft:  sub_a = 8'h01;
          ActDriveRight: sub_a = 8'h02;
          default:       ;
        endcase
      end
      MODE_ZOOM_RUN: begin
        case (cmd_i.action)
          ActZoomIn:   sub_a = 8'h02;
          ActZoomStop: sub_a = 8'h00;
          default:     sub_a = 8'h03;
        endcase
      end
      default: ;
    endcase
  end

  // Lay out the packet bytes; unknown modes and the rejected preset give length zero
  always_comb begin
    pkt_o.bytes    = '0;
    pkt_o.len      = '0;
    pkt_o.bytes[0] = PktHeader;
    unique case (mode_e'(cmd_i.mode))
      MODE_ABS_MOVE, MODE_REL_MOVE: begin
        pkt_o.bytes[1]  = 8'h01;
        pkt_o.bytes[2]  = 8'h06;
        pkt_o.bytes[3]  = (cmd_i.mode == MODE_REL_MOVE) ? 8'h03 : 8'h02;
        pkt_o.bytes[4]  = ps_byte;
        pkt_o.bytes[5]  = ts_byte;
        pkt_o.bytes[6]  = {4'h0, pan_c[15:12]};
        pkt_o.bytes[7]  = {4'h0, pan_c[11:8]};
        pkt_o.bytes[8]  = {4'h0, pan_c[7:4]};
        pkt_o.bytes[9]  = {4'h0, pan_c[3:0]};
        pkt_o.bytes[10] = {4'h0, tilt_c[15:12]};
        pkt_o.bytes[11] = {4'h0, tilt_c[11:8]};
        pkt_o.bytes[12] = {4'h0, tilt_c[7:4]};
        pkt_o.bytes[13] = {4'h0, tilt_c[3:0]};
        pkt_o.bytes[14] = PktTerm;
        pkt_o.len       = 4'd15;
      end
      MODE_ZOOM_SET: begin
        pkt_o.bytes[1] = 8'h01;
        pkt_o.bytes[2] = 8'h04;
        pkt_o.bytes[3] = 8'h47;
        pkt_o.bytes[4] = {4'h0, zoom_c[15:12]};
        pkt_o.bytes[5] = {4'h0, zoom_c[11:8]};
        pkt_o.bytes[6] = {4'h0, zoom_c[7:4]};
        pkt_o.bytes[7] = {4'h0, zoom_c[3:0]};
        pkt_o.bytes[8] = PktTerm;
        pkt_o.len      = 4'd9;
      end
      MODE_HOME: begin
        pkt_o.bytes[1] = 8'h01;
        pkt_o.bytes[2] = 8'h06;
        pkt_o.bytes[3] = 8'h04;
        pkt_o.bytes[4] = PktTerm;
        pkt_o.len      = 4'd5;
      end
      MODE_PRESET: begin
        pkt_o.bytes[1] = 8'h01;
        pkt_o.bytes[2] = 8'h04;
        pkt_o.bytes[3] = 8'h3F;
        pkt_o.bytes[4] = sub_a;
        pkt_o.bytes[5] = cmd_i.preset_number;
        pkt_o.bytes[6] = PktTerm;
        pkt_o.len      = (cmd_i.preset_number == 8'hFF) ? 4'd0 : 4'd7;
      end
      MODE_FOCUS: begin
        pkt_o.bytes[1] = 8'h01;
        pkt_o.bytes[2] = 8'h04;
        pkt_o.bytes[3] = sub_a;
        pkt_o.bytes[4] = sub_b;
        pkt_o.bytes[5] = PktTerm;
        pkt_o.len      = 4'd6;
      end
      MODE_DRIVE: begin
        pkt_o.bytes[1] = 8'h01;
        pkt_o.bytes[2] = 8'h06;
        pkt_o.bytes[3] = 8'h01;
        pkt_o.bytes[4] = ps_byte;
        pkt_o.bytes[5] = ts_byte;
        pkt_o.bytes[6] = sub_a;
        pkt_o.bytes[7] = sub_b;
        pkt_o.bytes[8] = PktTerm;
        pkt_o.len      = 4'd9;
      end
      MODE_ZOOM_RUN: begin
        pkt_o.bytes[1] = 8'h01;
        pkt_o.bytes[2] = 8'h04;
        pkt_o.bytes[3] = 8'h07;
        pkt_o.bytes[4] = sub_a;
        pkt_o.bytes[5] = PktTerm;
        pkt_o.len      = 4'd6;
      end
      MODE_POS_INQ: begin
        pkt_o.bytes[1] = 8'h09;
        pkt_o.bytes[2] = 8'h06;
        pkt_o.bytes[3] = 8'h12;
        pkt_o.bytes[4] = PktTerm;
        pkt_o.len      = 4'd5;
      end
      MODE_ZOOM_INQ: begin
        pkt_o.bytes[1] = 8'h09;
        pkt_o.bytes[2] = 8'h04;
        pkt_o.bytes[3] = 8'h47;
        pkt_o.bytes[4] = PktTerm;
        pkt_o.len      = 4'd5;
      end
      default: pkt_o.len = '0;
    endcase
  end

endmodule

### design/ptz_command_packet_builder.sv
// Top level of the PTZ command packet builder: command register, packet shifter, config.
//
//  channel   direction  handshake                  payload
//  ------    ---------  -------------------------  ---------------------------------------
//  in        input      in_valid_i / in_ready_o    mode, action, pan/tilt/zoom target, preset
//  out       output     out_valid_o / out_ready_i  packet_byte, packet_end
//  cfg       input      cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// A command is held in the command register until its packet (5 to 15 bytes) loads into
// the shift register and leaves one byte per cycle while the output is ready; the byte
// count of the packet sets the rate. The next command loads in the cycle the last byte is taken,
// so packets stream without gaps. A command that builds no packet is dropped as it loads.
// Reset clears both valid flags and sets the speeds to 24 and 20.
// A stalled output holds its byte; the command register holds the next request meanwhile.
module ptz_command_packet_builder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         mode_i,
  input  logic [2:0]         action_i,
  input  logic signed [15:0] pan_target_i,
  input  logic signed [15:0] tilt_target_i,
  input  logic signed [15:0] zoom_target_i,
  input  logic [7:0]         preset_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         packet_byte_o,
  output logic               packet_end_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [4:0]         cfg_data_i
);
  import ptzpb_pkg::*;

  logic                   in_valid_q, in_valid_d;
  cmd_t                   cmd_q;
  logic [PktMax-1:0][7:0] buf_q, buf_d;
  logic [LenW-1:0]        cnt_q, cnt_d;
  logic [4:0]             pan_speed_q, tilt_speed_q;
  pkt_t                   pkt;
  logic                   in_fire, out_fire, load;

  // Build the packet from the held command
  ptzpb_builder u_builder (
    .cmd_i       (cmd_q),
    .pan_speed_i (pan_speed_q),
    .tilt_speed_i(tilt_speed_q),
    .pkt_o       (pkt)
  );

  // Load when the shifter is empty or its last byte leaves now
  assign out_fire   = out_valid_o && out_ready_i;
  assign load       = in_valid_q && ((cnt_q == '0) || ((cnt_q == LenW'(1)) && out_ready_i));
  assign in_ready_o = !in_valid_q || load;
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o   = (cnt_q != '0);
  assign packet_byte_o = buf_q[0];
  assign packet_end_o  = (cnt_q == LenW'(1));

  // Capture the next request
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q.mode          <= mode_i;
      cmd_q.action        <= action_i;
      cmd_q.pan_target    <= pan_target_i;
      cmd_q.tilt_target   <= tilt_target_i;
      cmd_q.zoom_target   <= zoom_target_i;
      cmd_q.preset_number <= preset_number_i;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) in_valid_d = 1'b1;
    else if (load) in_valid_d = 1'b0;
  end

  // Load or advance the byte shifter
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load) begin
      buf_d = pkt.bytes;
      cnt_d = pkt.len;
    end else if (out_fire) begin
      for (int i = 0; i < PktMax - 1; i++) buf_d[i] = buf_q[i+1];
      buf_d[PktMax-1] = 8'h00;
      cnt_d = cnt_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      cnt_q      <= cnt_d;
    end
  end

  // Write speed registers, saturating to their limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_speed_q  <= PanSpeedMax;
      tilt_speed_q <= TiltSpeedMax;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegPanSpeed) begin
        pan_speed_q <= (cfg_data_i > PanSpeedMax) ? PanSpeedMax : cfg_data_i;
      end else if (cfg_idx_i == RegTiltSpeed) begin
        tilt_speed_q <= (cfg_data_i > TiltSpeedMax) ? TiltSpeedMax : cfg_data_i;
      end
    end
  end

  // Checks on the shifter and the command register
  a_end_is_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    packet_end_o |-> (packet_byte_o == PktTerm))
    else $error("packet end flag on a byte other than the terminator");

  a_load_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (pkt.len != '0)) |=> (out_valid_o && (packet_byte_o == PktHeader)))
    else $error("loaded packet does not start with the header byte");

  a_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !load) |=> (in_valid_q && $stable(cmd_q)))
    else $error("pending command lost before it was loaded");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pan_speed_q <= PanSpeedMax) && (tilt_speed_q <= TiltSpeedMax))
    else $error("speed register above its limit");

endmodule

### sim/ptz_command_packet_builder_tb.sv
// Self-checking testbench for the PTZ command packet builder: random commands, byte-level checks.
module ptz_command_packet_builder_tb;
  import ptzpb_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;

  // Clamp windows of the position fields
  localparam int PanLimit = 'h0990;
  localparam int TiltLow  = -'h01B0;
  localparam int TiltHigh = 'h0510;
  localparam int ZoomHigh = 'h4000;

  // Sub-operation codes per mode
  localparam logic [2:0] ActPresetGoto  = 3'd0;
  localparam logic [2:0] ActPresetSet   = 3'd1;
  localparam logic [2:0] ActPresetClear = 3'd2;
  localparam logic [2:0] ActFocusManual = 3'd0;
  localparam logic [2:0] ActFocusAuto   = 3'd1;
  localparam logic [2:0] ActFocusNear   = 3'd2;
  localparam logic [2:0] ActFocusFar    = 3'd3;
  localparam logic [2:0] ActFocusStop   = 3'd4;
  localparam logic [2:0] ActDriveStop   = 3'd0;
  localparam logic [2:0] ActDriveUp     = 3'd1;
  localparam logic [2:0] ActDriveDown   = 3'd2;
  localparam logic [2:0] ActDriveLeft   = 3'd3;
  localparam logic [2:0] ActDriveRight  = 3'd4;
  localparam logic [2:0] ActZoomIn      = 3'd0;
  localparam logic [2:0] ActZoomOut     = 3'd1;
  localparam logic [2:0] ActZoomStop    = 3'd2;
  localparam logic [2:0] ActUnused      = 3'd7;
  localparam logic [3:0] ModeUnknown    = 4'd15;
  localparam logic [7:0] PresetReject   = 8'hFF;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } pkt_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [3:0]         mode_i = '0;
  logic [2:0]         action_i = '0;
  logic signed [15:0] pan_target_i = '0;
  logic signed [15:0] tilt_target_i = '0;
  logic signed [15:0] zoom_target_i = '0;
  logic [7:0]         preset_number_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         packet_byte_o;
  logic               packet_end_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [4:0]         cfg_data_i = '0;

  cmd_t        cmd_backlog[$];
  pkt_byte_t   packet_bytes_due[$];
  cmd_t        cmd_on_port;
  logic [4:0]  cur_pan_speed = PanSpeedMax;
  logic [4:0]  cur_tilt_speed = TiltSpeedMax;
  int          n_queued = 0;
  int          n_taken = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned out_draw;
  bit          no_idle = 1'b0;

  ptz_command_packet_builder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .action_i       (action_i),
    .pan_target_i   (pan_target_i),
    .tilt_target_i  (tilt_target_i),
    .zoom_target_i  (zoom_target_i),
    .preset_number_i(preset_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .packet_byte_o  (packet_byte_o),
    .packet_end_o   (packet_end_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(string what, int want, int got);
    if (err_cnt < 40) begin
      $display("MISMATCH at cycle %0d: %s: expected %0h, got %0h", cycle_cnt, what, want, got);
    end
    err_cnt++;
  endtask

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Random field values at the width of their ports
  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    packet_bytes_due.push_back('{b, 1'b0});
  endfunction

  // Append a 16-bit position as four nibbles, most significant first
  function automatic void push_nibbles(int v);
    logic [15:0] u;
    u = v[15:0];
    push_byte({4'h0, u[15:12]});
    push_byte({4'h0, u[11:8]});
    push_byte({4'h0, u[7:4]});
    push_byte({4'h0, u[3:0]});
  endfunction

  // Build the packet a command should produce and queue its bytes
  function automatic void encode_command(cmd_t c);
    logic [7:0] b3, b4;
    if (c.mode > MODE_ZOOM_INQ) return;
    if (c.mode == MODE_PRESET && c.preset_number == PresetReject) return;
    push_byte(PktHeader);
    case (c.mode)
      MODE_ABS_MOVE, MODE_REL_MOVE: begin
        push_byte(8'h01);
        push_byte(8'h06);
        push_byte((c.mode == MODE_REL_MOVE) ? 8'h03 : 8'h02);
        push_byte({3'b000, cur_pan_speed});
        push_byte({3'b000, cur_tilt_speed});
        push_nibbles(clamp(int'(c.pan_target), -PanLimit, PanLimit));
        push_nibbles(clamp(int'(c.tilt_target), TiltLow, TiltHigh));
      end
      MODE_ZOOM_SET: begin
        push_byte(8'h01);
        push_byte(8'h04);
        push_byte(8'h47);
        push_nibbles(clamp(int'(c.zoom_target), 0, ZoomHigh));
      end
      MODE_HOME: begin
        push_byte(8'h01);
        push_byte(8'h06);
        push_byte(8'h04);
      end
      MODE_PRESET: begin
        push_byte(8'h01);
        push_byte(8'h04);
        push_byte(8'h3F);
        push_byte((c.action == ActPresetSet) ? 8'h01 :
                  (c.action == ActPresetClear) ? 8'h00 : 8'h02);
        push_byte(c.preset_number);
      end
      MODE_FOCUS: begin
        // Unknown focus actions fall back to auto
        b3 = 8'h38;
        b4 = 8'h02;
        case (c.action)
          ActFocusManual: b4 = 8'h03;
          ActFocusNear: begin
            b3 = 8'h08;
            b4 = 8'h02;
          end
          ActFocusFar: begin
            b3 = 8'h08;
            b4 = 8'h03;
          end
          ActFocusStop: begin
            b3 = 8'h08;
            b4 = 8'h00;
          end
          default: ;
        endcase
        push_byte(8'h01);
        push_byte(8'h04);
        push_byte(b3);
        push_byte(b4);
      end
      MODE_DRIVE: begin
        // b3 holds the horizontal code, b4 the vertical; unknown means stop
        b3 = 8'h03;
        b4 = 8'h03;
        case (c.action)
          ActDriveUp:    b4 = 8'h01;
          ActDriveDown:  b4 = 8'h02;
          ActDriveLeft:  b3 = 8'h01;
          ActDriveRight: b3 = 8'h02;
          default: ;
        endcase
        push_byte(8'h01);
        push_byte(8'h06);
        push_byte(8'h01);
        push_byte({3'b000, cur_pan_speed});
        push_byte({3'b000, cur_tilt_speed});
        push_byte(b3);
        push_byte(b4);
      end
      MODE_ZOOM_RUN: begin
        push_byte(8'h01);
        push_byte(8'h04);
        push_byte(8'h07);
        push_byte((c.action == ActZoomIn) ? 8'h02 :
                  (c.action == ActZoomStop) ? 8'h00 : 8'h03);
      end
      MODE_POS_INQ: begin
        push_byte(8'h09);
        push_byte(8'h06);
        push_byte(8'h12);
      end
      default: begin
        push_byte(8'h09);
        push_byte(8'h04);
        push_byte(8'h47);
      end
    endcase
    packet_bytes_due.push_back('{PktTerm, 1'b1});
  endfunction

  task automatic queue_cmd(logic [3:0] m, logic [2:0] a, logic [15:0] p, logic [15:0] t,
                           logic [15:0] z, logic [7:0] id);
    cmd_t c;
    c.mode          = m;
    c.action        = a;
    c.pan_target    = p;
    c.tilt_target   = t;
    c.zoom_target   = z;
    c.preset_number = id;
    cmd_backlog.push_back(c);
    n_queued++;
  endtask

  // Mix of full-range values, values around each clamp edge and values inside the window
  function automatic logic [15:0] rand_pos(int lo, int hi);
    int r;
    case ($urandom_range(0, 3))
      0:       r = int'($urandom);
      1:       r = lo - 4 + int'($urandom_range(0, 8));
      2:       r = hi - 4 + int'($urandom_range(0, 8));
      default: r = lo + int'($urandom_range(0, hi - lo));
    endcase
    return r[15:0];
  endfunction

  task automatic queue_random_cmd();
    int unsigned r;
    logic [3:0] m;
    logic [7:0] id;
    r = $urandom_range(0, 19);
    m = (r < 18) ? 4'(r % 10) : 4'($urandom_range(10, 15));
    id = ($urandom_range(0, 11) == 0) ? PresetReject : 8'($urandom_range(0, 255));
    queue_cmd(m, 3'($urandom_range(0, 7)), rand_pos(-PanLimit, PanLimit),
              rand_pos(TiltLow, TiltHigh), rand_pos(0, ZoomHigh), id);
  endtask

  // Write one speed register and track its saturated value
  task automatic set_speed(logic [1:0] idx, logic [4:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegPanSpeed) cur_pan_speed = (val > PanSpeedMax) ? PanSpeedMax : val;
    else cur_tilt_speed = (val > TiltSpeedMax) ? TiltSpeedMax : val;
  endtask

  // Hold until every queued command is taken and every packet byte has arrived
  task automatic wait_idle();
    while (!(n_taken == n_queued && packet_bytes_due.size() == 0)) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Command driver: present the backlog with random gaps between requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        encode_command(cmd_on_port);
        n_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= in_gap - 1;
        end else if (cmd_backlog.size() != 0) begin
          cmd_on_port = cmd_backlog.pop_front();
          mode_i          <= cmd_on_port.mode;
          action_i        <= cmd_on_port.action;
          pan_target_i    <= cmd_on_port.pan_target;
          tilt_target_i   <= cmd_on_port.tilt_target;
          zoom_target_i   <= cmd_on_port.zoom_target;
          preset_number_i <= cmd_on_port.preset_number;
          in_valid_i      <= 1'b1;
          in_gap          <= no_idle ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Byte monitor: check each taken byte against the oldest one due, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (packet_bytes_due.size() == 0) begin
        report_mismatch("byte with no packet outstanding", 0, int'(packet_byte_o));
      end else begin
        if (packet_byte_o !== packet_bytes_due[0].value)
          report_mismatch("packet_byte", int'(packet_bytes_due[0].value), int'(packet_byte_o));
        if (packet_end_o !== packet_bytes_due[0].last)
          report_mismatch("packet_end", int'(packet_bytes_due[0].last), int'(packet_end_o));
        void'(packet_bytes_due.pop_front());
      end
      out_draw = no_idle ? 0 : $urandom_range(0, 7);
      out_ready_i <= (out_draw == 0);
      out_gap     <= (out_draw == 0) ? 0 : out_draw - 1;
    end else if (!out_ready_i) begin
      if (out_gap == 0) out_ready_i <= 1'b1;
      else out_gap <= out_gap - 1;
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [4:0] pan_set [6];
    logic [4:0] tilt_set [6];
    pan_set  = '{5'd0, 5'd31, 5'd13, 5'd25, 5'd24, 5'd0};
    tilt_set = '{5'd0, 5'd31, 5'd7, 5'd21, 5'd20, 5'd0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed commands at the reset speeds: clamp edges, every mode and action
    queue_cmd(MODE_ABS_MOVE, ActUnused, 16'h7FFF, 16'h7FFF, rnd16(), rnd8());
    queue_cmd(MODE_REL_MOVE, ActPresetGoto, 16'h8000, 16'h8000, rnd16(), rnd8());
    queue_cmd(MODE_ZOOM_SET, ActPresetGoto, rnd16(), rnd16(), 16'h8000, rnd8());
    queue_cmd(MODE_ZOOM_SET, ActUnused, rnd16(), rnd16(), 16'h7FFF, rnd8());
    queue_cmd(MODE_HOME, ActUnused, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_PRESET, ActPresetGoto, rnd16(), rnd16(), rnd16(), 8'd0);
    queue_cmd(MODE_PRESET, ActPresetSet, rnd16(), rnd16(), rnd16(), 8'd254);
    queue_cmd(MODE_PRESET, ActPresetClear, rnd16(), rnd16(), rnd16(), 8'h55);
    queue_cmd(MODE_PRESET, ActUnused, rnd16(), rnd16(), rnd16(), 8'hAA);
    queue_cmd(MODE_PRESET, ActPresetSet, rnd16(), rnd16(), rnd16(), PresetReject);
    queue_cmd(MODE_FOCUS, ActFocusManual, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_FOCUS, ActFocusAuto, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_FOCUS, ActFocusNear, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_FOCUS, ActFocusFar, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_FOCUS, ActFocusStop, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_FOCUS, ActUnused, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_DRIVE, ActDriveStop, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_DRIVE, ActDriveUp, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_DRIVE, ActDriveDown, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_DRIVE, ActDriveLeft, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_DRIVE, ActDriveRight, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_DRIVE, ActUnused, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_ZOOM_RUN, ActZoomIn, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_ZOOM_RUN, ActZoomOut, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_ZOOM_RUN, ActZoomStop, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_ZOOM_RUN, ActUnused, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_POS_INQ, ActUnused, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(MODE_ZOOM_INQ, ActUnused, rnd16(), rnd16(), rnd16(), rnd8());
    queue_cmd(ModeUnknown, ActUnused, rnd16(), rnd16(), rnd16(), rnd8());
    wait_idle();

    // Random phases, each under its own speed setting; some run without idling
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        pan_set[ph]  = 5'($urandom_range(0, 31));
        tilt_set[ph] = 5'($urandom_range(0, 31));
      end
      set_speed(RegPanSpeed, pan_set[ph]);
      set_speed(RegTiltSpeed, tilt_set[ph]);
      no_idle = (ph == 2 || ph == 4);
      for (int i = 0; i < 25; i++) queue_random_cmd();
      wait_idle();
    end

    if (err_cnt == 0 && packet_bytes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
design/ptzpb_pkg.sv
design/ptzpb_builder.sv
design/ptz_command_packet_builder.sv
sim/ptz_command_packet_builder_tb.sv
